// ===== rtl/rcd_pkg.sv =====
`default_nettype none
package rcd_pkg;

  // Shared divider widths
  localparam int unsigned DIV_NUM_W = 32;
  localparam int unsigned DIV_DEN_W = 26;

  // Datapath widths
  localparam int unsigned COORD_W = 8;   // signed map coordinate, one step past either edge
  localparam int unsigned CAM_W   = 22;  // signed camera coordinate, Q.14
  localparam int unsigned PROD_W  = 38;  // plane times camera coordinate
  localparam int unsigned RAY_W   = 24;  // signed ray component, Q.14
  localparam int unsigned DIST_W  = 48;  // side distances and deltas, Q.16
  localparam int unsigned WALL_W  = 30;  // low bits of the wall hit position, Q.30

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_POS_X   = 3'd0,
    CFG_POS_Y   = 3'd1,
    CFG_DIR_X   = 3'd2,
    CFG_DIR_Y   = 3'd3,
    CFG_PLANE_X = 3'd4,
    CFG_PLANE_Y = 3'd5,
    CFG_PITCH   = 3'd6
  } rcd_cfg_idx_e;

  // Item kinds
  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_CAST  = 1'b1
  } rcd_kind_e;

  typedef struct packed {
    logic [21:0]        pos_x;
    logic [21:0]        pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
    logic signed [8:0]  pitch;
  } rcd_cfg_t;

  // Classified item passed from the front end to the walker
  typedef struct packed {
    rcd_kind_e  kind;
    logic       in_map;
    logic [8:0] column;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [7:0] code;
  } rcd_item_t;

  typedef struct packed {
    logic [5:0]  hit_x;
    logic [5:0]  hit_y;
    logic        hit_side;
    logic [21:0] wall_distance;
    logic [15:0] slice_height;
    logic [8:0]  draw_start;
    logic [8:0]  draw_end;
    logic [7:0]  texture_number;
    logic [5:0]  texture_column;
    logic        is_centre;
  } rcd_result_t;

endpackage
`default_nettype wire

// ===== rtl/raycast_column_dda.sv =====
// Grid raycaster for one screen column per cast item. Map writes (tuser 0) that fall inside
// the map go into the cell store once queued. A cast (tuser 1) forms its camera coordinate
// by a reciprocal multiplication, then runs up to three divisions on a shared radix-2
// divider (both ray deltas and the slice height, the last skipped when the distance is zero
// or too large for a nonzero height), and walks the grid in a step state and a check state
// per cell, since each step reads the cell store through its registered port; a clamp, an
// address and a code state follow when the ray leaves the map. After reset the cell store
// is cleared one entry per cycle, all MAP_COLS * MAP_ROWS entries, and no item is accepted
// until that is done; configuration writes are taken at any time and must only occur while
// the block is idle.
`default_nettype none
module raycast_column_dda
  import rcd_pkg::*;
#(
  parameter int unsigned MAP_COLS    = 32,
  parameter int unsigned MAP_ROWS    = 32,
  parameter int unsigned SCREEN_COLS = 320,
  parameter int unsigned SCREEN_ROWS = 240,
  parameter int unsigned TEX_SIZE    = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [21:0] cfg_wdata_i,
  // items in
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // column, cell_x, cell_y, cell_code
  input  wire logic [0:0]  s_axis_tuser_i,  // op
  // results out
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [87:0]      m_axis_tdata_o,  // hit_x, hit_y, hit_side, wall_distance,
                                            // slice_height, draw_start, draw_end,
                                            // texture_number, texture_column
  output logic [0:0]       m_axis_tuser_o   // is_centre
);

  rcd_cfg_t    cfg_q;
  rcd_item_t   front_item, queue_item;
  rcd_result_t result;
  logic        push, full, pop, queue_valid, clear_done;

  // Camera registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_x   <= 22'd1441792;
      cfg_q.pos_y   <= 22'd786432;
      cfg_q.dir_x   <= -16'sd16384;
      cfg_q.dir_y   <= 16'sd0;
      cfg_q.plane_x <= 16'sd0;
      cfg_q.plane_y <= 16'sd16384;
      cfg_q.pitch   <= 9'sd0;
    end else if (cfg_we_i) begin
      case (rcd_cfg_idx_e'(cfg_addr_i))
        CFG_POS_X:   cfg_q.pos_x   <= cfg_wdata_i;
        CFG_POS_Y:   cfg_q.pos_y   <= cfg_wdata_i;
        CFG_DIR_X:   cfg_q.dir_x   <= cfg_wdata_i[15:0];
        CFG_DIR_Y:   cfg_q.dir_y   <= cfg_wdata_i[15:0];
        CFG_PLANE_X: cfg_q.plane_x <= cfg_wdata_i[15:0];
        CFG_PLANE_Y: cfg_q.plane_y <= cfg_wdata_i[15:0];
        CFG_PITCH:   cfg_q.pitch   <= cfg_wdata_i[8:0];
        default: begin
        end
      endcase
    end
  end

  rcd_front #(
    .MAP_COLS (MAP_COLS),
    .MAP_ROWS (MAP_ROWS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (clear_done),
    .s_axis_tvalid (s_axis_tvalid_i),
    .s_axis_tready (s_axis_tready_o),
    .s_axis_tdata  (s_axis_tdata_i),
    .s_axis_tuser  (s_axis_tuser_i),
    .push_o        (push),
    .item_o        (front_item),
    .full_i        (full)
  );

  rcd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  rcd_back #(
    .MAP_COLS    (MAP_COLS),
    .MAP_ROWS    (MAP_ROWS),
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .TEX_SIZE    (TEX_SIZE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .pop_o        (pop),
    .clear_done_o (clear_done),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .result_o     (result)
  );

  // Pack result, first field lowest
  assign m_axis_tdata_o = {5'd0, result.texture_column, result.texture_number,
                           result.draw_end, result.draw_start, result.slice_height,
                           result.wall_distance, result.hit_side, result.hit_y,
                           result.hit_x};
  assign m_axis_tuser_o = result.is_centre;

endmodule
`default_nettype wire

// ===== rtl/rcd_div.sv =====
`default_nettype none
module rcd_div
  import rcd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DIV_NUM_W-1:0] dividend_i,
  input  wire logic [DIV_DEN_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [DIV_NUM_W-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIV_NUM_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_DEN_W-1:0] rem_q, den_q;
  logic [DIV_NUM_W-1:0] quo_q;

  logic [DIV_DEN_W:0] trial, diff;
  logic               ge;

  // One restoring step per cycle
  assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ===== rtl/rcd_front.sv =====
`default_nettype none
module rcd_front
  import rcd_pkg::*;
#(
  parameter int unsigned MAP_COLS = 32,
  parameter int unsigned MAP_ROWS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic [0:0]  s_axis_tuser,
  output logic             push_o,
  output rcd_item_t        item_o,
  input  wire logic        full_i
);

  logic      valid_q;
  rcd_item_t item_q;
  rcd_item_t item_d;

  // Classify: kind from tuser, map bounds for writes
  always_comb begin
    item_d.kind   = rcd_kind_e'(s_axis_tuser[0]);
    item_d.column = s_axis_tdata[8:0];
    item_d.cell_x = s_axis_tdata[14:9];
    item_d.cell_y = s_axis_tdata[20:15];
    item_d.code   = s_axis_tdata[28:21];
    item_d.in_map = ({1'b0, s_axis_tdata[14:9]} < 7'(MAP_COLS)) &&
                    ({1'b0, s_axis_tdata[20:15]} < 7'(MAP_ROWS));
  end

  assign push_o        = valid_q && !full_i;
  assign s_axis_tready = en_i && (!valid_q || !full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule
`default_nettype wire

// ===== rtl/rcd_fifo.sv =====
`default_nettype none
module rcd_fifo
  import rcd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  rcd_item_t item_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output rcd_item_t item_o
);

  // Two-entry queue between front end and walker
  rcd_item_t  slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign item_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= item_i;
  end

endmodule
`default_nettype wire

// ===== rtl/rcd_back.sv =====
`default_nettype none
module rcd_back
  import rcd_pkg::*;
#(
  parameter int unsigned MAP_COLS    = 32,
  parameter int unsigned MAP_ROWS    = 32,
  parameter int unsigned SCREEN_COLS = 320,
  parameter int unsigned SCREEN_ROWS = 240,
  parameter int unsigned TEX_SIZE    = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  rcd_cfg_t   cfg_i,
  input  wire logic  item_valid_i,
  input  rcd_item_t  item_i,
  output logic       pop_o,
  output logic       clear_done_o,
  output logic       m_valid_o,
  input  wire logic  m_ready_i,
  output rcd_result_t result_o
);

  localparam int unsigned DEPTH = MAP_COLS * MAP_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic signed [COORD_W-1:0] COLS_S = COORD_W'(MAP_COLS);
  localparam logic signed [COORD_W-1:0] ROWS_S = COORD_W'(MAP_ROWS);
  localparam logic [AW-1:0]        ROW_STEP = AW'(MAP_ROWS);
  localparam logic [DIST_W-1:0]    DIST_INF = DIST_W'(1) << 40;
  localparam logic [DIV_NUM_W-1:0] ONE_Q30  = DIV_NUM_W'(1) << 30;
  localparam logic [DIV_NUM_W-1:0] H_NUM    = DIV_NUM_W'(SCREEN_ROWS * 65536);
  // ceil(2^34 / SCREEN_COLS): exact floor of column * 2^15 / SCREEN_COLS for 9-bit columns
  localparam logic [31:0] CAM_RECIP =
    32'(((64'd1 << 34) + 64'(SCREEN_COLS) - 64'd1) / 64'(SCREEN_COLS));

  typedef enum logic [20:0] {
    S_CLEAR = 21'd1,
    S_IDLE  = 21'd2,
    S_CAM   = 21'd4,
    S_RAYM  = 21'd8,
    S_RAYA  = 21'd16,
    S_DXS   = 21'd32,
    S_DXW   = 21'd64,
    S_DYW   = 21'd128,
    S_SD    = 21'd256,
    S_STEP  = 21'd512,
    S_CHK   = 21'd1024,
    S_CLAMP = 21'd2048,
    S_CADDR = 21'd4096,
    S_CCODE = 21'd8192,
    S_PERP  = 21'd16384,
    S_WALL  = 21'd32768,
    S_TEX   = 21'd65536,
    S_HS    = 21'd131072,
    S_HW    = 21'd262144,
    S_ROWS  = 21'd524288,
    S_DONE  = 21'd1048576
  } back_state_e;

  back_state_e state_q, state_d;
  logic [AW-1:0] clr_addr_q;
  logic          out_valid_q;
  rcd_result_t   result_q;

  // Cell store
  logic [7:0]    mem [DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, rd_data_q;

  // Walk state
  logic [8:0]                  col_q;
  logic signed [CAM_W-1:0]     cam_q;
  logic signed [PROD_W-1:0]    prodx_q, prody_q;
  logic signed [RAY_W-1:0]     rx_q, ry_q;
  logic [DIST_W-1:0]           ddx_q, ddy_q, sdx_q, sdy_q, perp_q;
  logic signed [COORD_W-1:0]   mx_q, my_q;
  logic [AW-1:0]               addr_q;
  logic                        side_q;
  logic [7:0]                  code_q;
  logic [WALL_W-1:0]           wprod_q;
  logic [5:0]                  tx_q;
  logic [15:0]                 h_q;
  logic [8:0]                  ds_q, de_q;

  // Divider hookup
  logic                 div_start, div_busy, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic [DIV_DEN_W-1:0] div_den;

  rcd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Helpers
  logic [RAY_W-1:0]          abs_rx, abs_ry;
  logic                      step_x, mx_out, my_out, perp_zero, perp_big, load_out;
  logic signed [COORD_W-1:0] mx_step, my_step;
  logic [AW-1:0]             addr_step, addr_clamp;
  logic [16:0]               f_x, f_y;
  logic [WALL_W-1:0]         wall_w;
  logic [21:0]               tprod;
  logic [5:0]                tx_raw;
  logic                      mirror;
  logic signed [17:0]        centre, half, ds_w, de_w;
  logic [40:0]               cam_prod;

  assign abs_rx    = rx_q[RAY_W-1] ? RAY_W'(-rx_q) : RAY_W'(rx_q);
  assign abs_ry    = ry_q[RAY_W-1] ? RAY_W'(-ry_q) : RAY_W'(ry_q);
  assign step_x    = sdx_q < sdy_q;
  assign mx_step   = rx_q[RAY_W-1] ? mx_q - COORD_W'(1) : mx_q + COORD_W'(1);
  assign my_step   = ry_q[RAY_W-1] ? my_q - COORD_W'(1) : my_q + COORD_W'(1);
  assign mx_out    = (mx_q < 0) || (mx_q >= COLS_S);
  assign my_out    = (my_q < 0) || (my_q >= ROWS_S);
  assign perp_zero = perp_q == '0;
  assign perp_big  = |perp_q[DIST_W-1:DIV_DEN_W];
  assign f_x       = rx_q[RAY_W-1] ? {1'b0, cfg_i.pos_x[15:0]} : 17'h10000 - {1'b0, cfg_i.pos_x[15:0]};
  assign f_y       = ry_q[RAY_W-1] ? {1'b0, cfg_i.pos_y[15:0]} : 17'h10000 - {1'b0, cfg_i.pos_y[15:0]};
  assign load_out  = (state_q == S_DONE) && (!out_valid_q || m_ready_i);

  // Camera coordinate by reciprocal multiplication
  assign cam_prod  = 41'(col_q) * 41'(CAM_RECIP);

  always_comb begin
    if (step_x) begin
      addr_step = rx_q[RAY_W-1] ? addr_q - ROW_STEP : addr_q + ROW_STEP;
    end else begin
      addr_step = ry_q[RAY_W-1] ? addr_q - AW'(1) : addr_q + AW'(1);
    end
  end

  assign addr_clamp = AW'(32'(mx_q[5:0]) * MAP_ROWS + 32'(my_q[5:0]));

  // Texture column from the wall hit fraction
  assign wall_w = (side_q ? {cfg_i.pos_x[15:0], 14'd0} : {cfg_i.pos_y[15:0], 14'd0}) + wprod_q;
  assign tprod  = 22'(wall_w[29:14]) * 22'(TEX_SIZE);
  assign tx_raw = tprod[21:16];
  assign mirror = (!side_q && !rx_q[RAY_W-1] && (rx_q != '0)) || (side_q && ry_q[RAY_W-1]);

  // Drawn rows around the horizon
  assign centre = 18'(SCREEN_ROWS / 2) + 18'(cfg_i.pitch);
  assign half   = {3'd0, h_q[15:1]};
  assign ds_w   = centre - half;
  assign de_w   = centre + half;

  // Divider requests
  always_comb begin
    div_start = 1'b0;
    div_num   = ONE_Q30;
    div_den   = DIV_DEN_W'(abs_rx);
    case (state_q)
      S_DXS: begin
        div_start = 1'b1;
      end
      S_DXW: begin
        div_start = div_done;
        div_den   = DIV_DEN_W'(abs_ry);
      end
      S_HS: begin
        div_start = !perp_zero && !perp_big;
        div_num   = H_NUM;
        div_den   = perp_q[DIV_DEN_W-1:0];
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Store access
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_q;
    mem_wdata = 8'd0;
    mem_re    = 1'b0;
    mem_raddr = addr_step;
    case (state_q)
      S_CLEAR: mem_we = 1'b1;
      S_IDLE: begin
        mem_we    = item_valid_i && (item_i.kind == KIND_WRITE) && item_i.in_map;
        mem_waddr = AW'(32'(item_i.cell_x) * MAP_ROWS + 32'(item_i.cell_y));
        mem_wdata = item_i.code;
      end
      S_STEP:  mem_re = 1'b1;
      S_CADDR: begin
        mem_re    = 1'b1;
        mem_raddr = addr_clamp;
      end
      default: mem_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rd_data_q <= mem[mem_raddr];
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_addr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
      S_IDLE:  if (item_valid_i && (item_i.kind == KIND_CAST)) state_d = S_CAM;
      S_CAM:   state_d = S_RAYM;
      S_RAYM:  state_d = S_RAYA;
      S_RAYA:  state_d = S_DXS;
      S_DXS:   state_d = S_DXW;
      S_DXW:   if (div_done) state_d = S_DYW;
      S_DYW:   if (div_done) state_d = S_SD;
      S_SD:    state_d = S_STEP;
      S_STEP:  state_d = S_CHK;
      S_CHK: begin
        if (mx_out || my_out) state_d = S_CLAMP;
        else if (rd_data_q != 8'd0) state_d = S_PERP;
        else state_d = S_STEP;
      end
      S_CLAMP: state_d = S_CADDR;
      S_CADDR: state_d = S_CCODE;
      S_CCODE: state_d = S_PERP;
      S_PERP:  state_d = S_WALL;
      S_WALL:  state_d = S_TEX;
      S_TEX:   state_d = S_HS;
      S_HS:    state_d = (perp_zero || perp_big) ? S_ROWS : S_HW;
      S_HW:    if (div_done) state_d = S_ROWS;
      S_ROWS:  state_d = S_DONE;
      S_DONE:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_addr_q <= clr_addr_q + AW'(1);
      if (load_out) out_valid_q <= 1'b1;
      else if (m_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: col_q <= item_i.column;
      S_CAM: begin
        cam_q <= $signed(cam_prod[40:19]) - $signed(CAM_W'(16384));
      end
      S_RAYM: begin
        prodx_q <= $signed(cfg_i.plane_x) * cam_q;
        prody_q <= $signed(cfg_i.plane_y) * cam_q;
      end
      S_RAYA: begin
        rx_q <= RAY_W'($signed(cfg_i.dir_x) + (prodx_q >>> 14));
        ry_q <= RAY_W'($signed(cfg_i.dir_y) + (prody_q >>> 14));
      end
      S_DXW: if (div_done) ddx_q <= (rx_q == '0) ? DIST_INF : DIST_W'(div_quot);
      S_DYW: if (div_done) ddy_q <= (ry_q == '0) ? DIST_INF : DIST_W'(div_quot);
      S_SD: begin
        sdx_q  <= ddx_q[40] ? DIST_W'({f_x, 24'd0})
                            : DIST_W'((DIST_W'(f_x) * DIST_W'(ddx_q[30:0])) >> 16);
        sdy_q  <= ddy_q[40] ? DIST_W'({f_y, 24'd0})
                            : DIST_W'((DIST_W'(f_y) * DIST_W'(ddy_q[30:0])) >> 16);
        mx_q   <= COORD_W'(cfg_i.pos_x[21:16]);
        my_q   <= COORD_W'(cfg_i.pos_y[21:16]);
        addr_q <= AW'(32'(cfg_i.pos_x[21:16]) * MAP_ROWS + 32'(cfg_i.pos_y[21:16]));
      end
      S_STEP: begin
        addr_q <= addr_step;
        if (step_x) begin
          sdx_q  <= sdx_q + ddx_q;
          mx_q   <= mx_step;
          side_q <= 1'b0;
        end else begin
          sdy_q  <= sdy_q + ddy_q;
          my_q   <= my_step;
          side_q <= 1'b1;
        end
      end
      S_CHK: code_q <= rd_data_q;
      S_CLAMP: begin
        if (mx_q < 0) mx_q <= '0;
        else if (mx_q >= COLS_S) mx_q <= COLS_S - COORD_W'(1);
        if (my_q < 0) my_q <= '0;
        else if (my_q >= ROWS_S) my_q <= ROWS_S - COORD_W'(1);
      end
      S_CCODE: code_q <= rd_data_q;
      S_PERP:  perp_q <= side_q ? sdy_q - ddy_q : sdx_q - ddx_q;
      S_WALL: begin
        wprod_q <= WALL_W'(perp_q[WALL_W-1:0] *
                           (side_q ? WALL_W'(rx_q) : WALL_W'(ry_q)));
      end
      S_TEX: tx_q <= mirror ? 6'(TEX_SIZE - 1) - tx_raw : tx_raw;
      S_HS: begin
        if (perp_zero) h_q <= 16'hFFFF;
        else if (perp_big) h_q <= 16'd0;
      end
      S_HW: begin
        if (div_done) begin
          h_q <= (|div_quot[DIV_NUM_W-1:16]) ? 16'hFFFF : div_quot[15:0];
        end
      end
      S_ROWS: begin
        ds_q <= (ds_w < 0) ? 9'd0 : ds_w[8:0];
        if (de_w >= $signed(18'(SCREEN_ROWS))) de_q <= 9'(SCREEN_ROWS - 1);
        else if (de_w < 0) de_q <= 9'd0;
        else de_q <= de_w[8:0];
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      result_q.hit_x          <= mx_q[5:0];
      result_q.hit_y          <= my_q[5:0];
      result_q.hit_side       <= side_q;
      result_q.wall_distance  <= (perp_q > DIST_W'(22'h3FFFFF)) ? 22'h3FFFFF : perp_q[21:0];
      result_q.slice_height   <= h_q;
      result_q.draw_start     <= ds_q;
      result_q.draw_end       <= de_q;
      result_q.texture_number <= (code_q != 8'd0) ? code_q - 8'd1 : 8'd0;
      result_q.texture_column <= tx_q;
      result_q.is_centre      <= col_q == 9'(SCREEN_COLS / 2);
    end
  end

  assign pop_o        = (state_q == S_IDLE) && item_valid_i;
  assign clear_done_o = state_q != S_CLEAR;
  assign m_valid_o    = out_valid_q;
  assign result_o     = result_q;

`ifndef ASSERT_OFF
  a_mem_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_IDLE))
    else $error("cell store written during a cast");
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");
  a_hit_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PERP) |-> (mx_q >= 0 && mx_q < COLS_S && my_q >= 0 && my_q < ROWS_S))
    else $error("hit cell outside the map");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !m_ready_i) |=> (state_q == S_DONE))
    else $error("result dropped while output stalled");
`endif

endmodule
`default_nettype wire
